>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers, clocked on i_clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of i_clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checks that cond never holds outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/rvh_pkg.sv
// ----------------------------------------------------------------------------
// rvh_pkg
// Types and constants shared by the RGBA value histogram modules.
// ----------------------------------------------------------------------------
package rvh_pkg;

    localparam int DEF_LEVELS      = 256;
    localparam int DEF_COUNT_WIDTH = 32;
    localparam int NUM_CH          = 5;
    localparam int COLOR_CH        = 4;
    localparam int CH_W            = 3;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_PIXEL  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [CH_W-1:0] CH_VALUE = 3'd0;
    localparam logic [CH_W-1:0] CH_RED   = 3'd1;
    localparam logic [CH_W-1:0] CH_GREEN = 3'd2;
    localparam logic [CH_W-1:0] CH_BLUE  = 3'd3;
    localparam logic [CH_W-1:0] CH_ALPHA = 3'd4;

    typedef struct packed {
        logic [1:0]      op;
        logic [7:0]      red;
        logic [7:0]      green;
        logic [7:0]      blue;
        logic [7:0]      alpha;
        logic [CH_W-1:0] channel;
        logic [7:0]      bin;
    } t_in_item;

    typedef struct packed {
        logic [31:0] bin_count;
        logic [31:0] peak_count;
        logic [7:0]  min_level;
        logic [7:0]  max_level;
        logic [31:0] pixel_total;
        logic        channel_active;
    } t_out_item;

    // Classified command as it sits in the queue; levels are already clamped.
    typedef struct packed {
        logic [1:0]      op;
        logic [7:0]      lvl_alpha;
        logic [7:0]      lvl_blue;
        logic [7:0]      lvl_green;
        logic [7:0]      lvl_red;
        logic [7:0]      lvl_value;
        logic [CH_W-1:0] channel;
        logic [7:0]      bin;
        logic            bin_oob;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_out;

endpackage

>>> rtl/rvh_front.sv
// ----------------------------------------------------------------------------
// rvh_front
// Accepts commands, derives the value level, clamps levels and queues them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rvh_front #(
    parameter int LEVELS = rvh_pkg::DEF_LEVELS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  rvh_pkg::t_in_item i_item,
    output logic              o_busy,
    output rvh_pkg::t_q_out   o_q,
    input  logic              i_pop
);
    import rvh_pkg::*;

    localparam logic [7:0] TOP = 8'(LEVELS - 1);

    t_cmd       r_q [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;
    t_cmd       cls;
    logic [7:0] v;
    logic       push;

    function automatic logic [7:0] clamp(input logic [7:0] x);
        return (x > TOP) ? TOP : x;
    endfunction

    always_comb begin
        v = i_item.red;
        if (i_item.green > v) v = i_item.green;
        if (i_item.blue > v) v = i_item.blue;
        cls.op        = i_item.op;
        cls.lvl_value = clamp(v);
        cls.lvl_red   = clamp(i_item.red);
        cls.lvl_green = clamp(i_item.green);
        cls.lvl_blue  = clamp(i_item.blue);
        cls.lvl_alpha = clamp(i_item.alpha);
        cls.channel   = i_item.channel;
        cls.bin       = i_item.bin;
        cls.bin_oob   = i_item.bin > TOP;
    end

    assign o_busy = (r_count == 2'd2);
    // Unused op code 3 is accepted and dropped here.
    assign push   = i_start && !o_busy && (i_item.op != OP_UNUSED);

    assign o_q.valid = (r_count != 2'd0);
    assign o_q.cmd   = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr ^ push;
        n_rd_ptr = r_rd_ptr ^ i_pop;
        n_count  = r_count + 2'(push) - 2'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    `ASSERT_CLK(a_count_range, r_count <= 2'd2, "queue count out of range")
    `ASSERT_NEVER(a_pop_empty, i_pop && r_count == 2'd0, "pop from empty queue")
    `ASSERT_CLK(a_count_track, push && !i_pop |=> r_count == $past(r_count) + 2'd1,
        "queue count did not follow a push")
endmodule

>>> rtl/rvh_back.sv
// ----------------------------------------------------------------------------
// rvh_back
// Executes queued commands: bin clearing sweep, read-modify-write of the bin
// memories for pixels, and bin reads with the channel summary.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rvh_back #(
    parameter int LEVELS      = rvh_pkg::DEF_LEVELS,
    parameter int COUNT_WIDTH = rvh_pkg::DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_alpha_enable,
    input  rvh_pkg::t_q_out    i_q,
    output logic               o_pop,
    output logic               o_result_valid,
    output rvh_pkg::t_out_item o_result
);
    import rvh_pkg::*;

    localparam int LW = $clog2(LEVELS);
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_PIX_RD = 3'd2;
    localparam logic [2:0] S_PIX_WR = 3'd3;
    localparam logic [2:0] S_RD_RD  = 3'd4;
    localparam logic [2:0] S_RD_OUT = 3'd5;

    logic [COUNT_WIDTH-1:0] mem [NUM_CH][LEVELS];
    logic [COUNT_WIDTH-1:0] r_rd [NUM_CH];
    logic [COUNT_WIDTH-1:0] r_peak [NUM_CH];
    logic [7:0]             r_low [NUM_CH];
    logic [7:0]             r_high [NUM_CH];
    logic [COUNT_WIDTH-1:0] r_pixels;
    logic                   r_frame_open;
    logic                   r_frame_alpha;
    logic [2:0]             r_state, n_state;
    logic [LW-1:0]          r_addr;
    t_cmd                   r_cmd;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic [7:0]             lvl [NUM_CH];
    logic [LW-1:0]          rd_addr [NUM_CH];
    logic [COUNT_WIDTH-1:0] inc [NUM_CH];
    logic                   ch_en [NUM_CH];
    logic                   active;
    t_out_item              res;

    function automatic logic [31:0] out32(input logic [COUNT_WIDTH-1:0] x);
        logic [63:0] e;
        e = 64'(x);
        return (e > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
    endfunction

    always_comb begin
        lvl[0] = r_cmd.lvl_value;
        lvl[1] = r_cmd.lvl_red;
        lvl[2] = r_cmd.lvl_green;
        lvl[3] = r_cmd.lvl_blue;
        lvl[4] = r_cmd.lvl_alpha;
        for (int c = 0; c < NUM_CH; c++) begin
            rd_addr[c] = (r_state == S_RD_RD) ? r_cmd.bin[LW-1:0] : lvl[c][LW-1:0];
            inc[c]     = (r_rd[c] == '1) ? r_rd[c] : r_rd[c] + 1'b1;
            ch_en[c]   = (c < COLOR_CH) || r_frame_alpha;
        end
    end

    assign o_pop = i_q.valid && (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop) begin
                    unique case (i_q.cmd.op)
                        OP_START: n_state = S_CLEAR;
                        OP_PIXEL: n_state = r_frame_open ? S_PIX_RD : S_IDLE;
                        OP_READ:  n_state = S_RD_RD;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_CLEAR:  n_state = (r_addr == LW'(LEVELS - 1)) ? S_IDLE : S_CLEAR;
            S_PIX_RD: n_state = S_PIX_WR;
            S_PIX_WR: n_state = S_IDLE;
            S_RD_RD:  n_state = S_RD_OUT;
            S_RD_OUT: n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // One memory per channel so a pixel's enabled bins, up to five, update together.
    for (genvar g = 0; g < NUM_CH; g++) begin : g_mem
        always_ff @(posedge i_clk) begin
            if (r_state == S_CLEAR) begin
                mem[g][r_addr] <= '0;
            end else if (r_state == S_PIX_WR && ch_en[g]) begin
                mem[g][lvl[g][LW-1:0]] <= inc[g];
            end
            r_rd[g] <= mem[g][rd_addr[g]];
        end
    end

    always_comb begin
        active = r_frame_open &&
                 ((r_cmd.channel < CH_W'(COLOR_CH)) ||
                  (r_cmd.channel == CH_ALPHA && r_frame_alpha));
        res = '0;
        if (active) begin
            res.bin_count      = r_cmd.bin_oob ? 32'd0 : out32(r_rd[r_cmd.channel]);
            res.peak_count     = out32(r_peak[r_cmd.channel]);
            res.min_level      = r_low[r_cmd.channel];
            res.max_level      = r_high[r_cmd.channel];
            res.pixel_total    = out32(r_pixels);
            res.channel_active = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q.cmd;
        end
        if (r_state == S_RD_OUT) begin
            r_out <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_addr        <= '0;
            r_pixels      <= '0;
            r_frame_open  <= 1'b0;
            r_frame_alpha <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int c = 0; c < NUM_CH; c++) begin
                r_peak[c] <= '0;
                r_low[c]  <= 8'hFF;
                r_high[c] <= 8'h00;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= (r_state == S_RD_OUT);
            if (o_pop && i_q.cmd.op == OP_START) begin
                r_addr        <= '0;
                r_pixels      <= '0;
                r_frame_open  <= 1'b1;
                r_frame_alpha <= i_alpha_enable;
                for (int c = 0; c < NUM_CH; c++) begin
                    r_peak[c] <= '0;
                    r_low[c]  <= 8'hFF;
                    r_high[c] <= 8'h00;
                end
            end
            if (r_state == S_CLEAR) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_state == S_PIX_WR) begin
                if (r_pixels != '1) begin
                    r_pixels <= r_pixels + 1'b1;
                end
                for (int c = 0; c < NUM_CH; c++) begin
                    if (ch_en[c]) begin
                        if (inc[c] > r_peak[c]) r_peak[c] <= inc[c];
                        if (lvl[c] < r_low[c])  r_low[c]  <= lvl[c];
                        if (lvl[c] > r_high[c]) r_high[c] <= lvl[c];
                    end
                end
            end
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    `ASSERT_CLK(a_strobe_origin, o_result_valid |-> $past(r_state) == S_RD_OUT,
        "result strobe without a read")
    `ASSERT_CLK(a_strobe_single, o_result_valid |=> !o_result_valid,
        "result strobe longer than one cycle")
    `ASSERT_NEVER(a_pix_no_frame, r_pixels != '0 && !r_frame_open,
        "pixels counted with no frame open")
    `ASSERT_NEVER(a_pop_busy, o_pop && r_state != S_IDLE,
        "command taken while back end busy")
endmodule

>>> rtl/rgba_value_histogram_top.sv
// A read passes the queue, S_RD_RD, S_RD_OUT and the result register before its
// strobe; a pixel holds the back end in S_PIX_RD and S_PIX_WR, a frame start in
// S_CLEAR for a sweep of all LEVELS bins. No new pixel is taken until the last
// one's read-modify-write of the bin memories is done; a full two-entry command
// queue sets busy. Results cannot be stalled. Reset clears control, summary and
// frame state; bin memories are cleared by each frame start's sweep before use.
// ----------------------------------------------------------------------------
// rgba_value_histogram_top
// Per-frame level histograms of value, red, green, blue and optional alpha.
// ----------------------------------------------------------------------------
module rgba_value_histogram_top #(
    parameter int LEVELS      = rvh_pkg::DEF_LEVELS,
    parameter int COUNT_WIDTH = rvh_pkg::DEF_COUNT_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  rvh_pkg::t_in_item  i_item,
    output logic               o_result_valid,
    output rvh_pkg::t_out_item o_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_data
);
    import rvh_pkg::*;

    logic   r_alpha_enable;
    t_q_out q;
    logic   pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_enable <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_alpha_enable <= i_cfg_data;
        end
    end

    rvh_front #(
        .LEVELS (LEVELS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_item  (i_item),
        .o_busy  (busy),
        .o_q     (q),
        .i_pop   (pop)
    );

    rvh_back #(
        .LEVELS      (LEVELS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_alpha_enable (r_alpha_enable),
        .i_q            (q),
        .o_pop          (pop),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );
endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// RGBA value histogram testbench
// Drives frame starts, pixels, bin reads and unused ops through the command port,
// keeps a behavioral histogram model and checks every read result field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import rvh_pkg::*;

    localparam int DRAIN_CYCLES = 300;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_item  i_item = '0;
    logic      o_result_valid;
    t_out_item o_result;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic      i_cfg_data = 1'b0;

    rgba_value_histogram_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_item        (i_item),
        .o_result_valid(o_result_valid),
        .o_result      (o_result),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Histogram model state.
    logic [31:0] hist_bins [NUM_CH][256];
    logic [31:0] hist_peak [NUM_CH];
    logic [7:0]  hist_low [NUM_CH];
    logic [7:0]  hist_high [NUM_CH];
    logic [31:0] hist_pixels;
    logic        hist_frame_open;
    logic        hist_frame_alpha;
    logic        hist_alpha_enable;

    t_out_item expected_reads [$];
    int        errors = 0;

    function automatic logic [31:0] sat_add1(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic hist_clear();
        for (int c = 0; c < NUM_CH; c++) begin
            for (int l = 0; l < 256; l++) hist_bins[c][l] = '0;
            hist_peak[c] = '0;
            hist_low[c]  = 8'd255;
            hist_high[c] = '0;
        end
        hist_pixels = '0;
    endtask

    task automatic hist_take(int ch, logic [7:0] lvl);
        hist_bins[ch][lvl] = sat_add1(hist_bins[ch][lvl]);
        if (hist_bins[ch][lvl] > hist_peak[ch]) hist_peak[ch] = hist_bins[ch][lvl];
        if (lvl < hist_low[ch]) hist_low[ch] = lvl;
        if (lvl > hist_high[ch]) hist_high[ch] = lvl;
    endtask

    // Applies one accepted command to the model and, for a read, queues its result.
    task automatic hist_apply(t_in_item it);
        logic [7:0] val;
        logic       active;
        t_out_item  r;
        r = '0;
        case (it.op)
            OP_START: begin
                hist_clear();
                hist_frame_open  = 1'b1;
                hist_frame_alpha = hist_alpha_enable;
            end
            OP_PIXEL: begin
                if (hist_frame_open) begin
                    val = it.red;
                    if (it.green > val) val = it.green;
                    if (it.blue > val) val = it.blue;
                    hist_take(CH_VALUE, val);
                    hist_take(CH_RED, it.red);
                    hist_take(CH_GREEN, it.green);
                    hist_take(CH_BLUE, it.blue);
                    if (hist_frame_alpha) hist_take(CH_ALPHA, it.alpha);
                    hist_pixels = sat_add1(hist_pixels);
                end
            end
            OP_READ: begin
                active = hist_frame_open && (it.channel < COLOR_CH ||
                         (it.channel == CH_ALPHA && hist_frame_alpha));
                if (active) begin
                    r.bin_count      = hist_bins[it.channel][it.bin];
                    r.peak_count     = hist_peak[it.channel];
                    r.min_level      = hist_low[it.channel];
                    r.max_level      = hist_high[it.channel];
                    r.pixel_total    = hist_pixels;
                    r.channel_active = 1'b1;
                end
                expected_reads.push_back(r);
            end
            default: ;
        endcase
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        t_out_item e;
        if (i_rst_n && o_result_valid) begin
            if (expected_reads.size() == 0) begin
                $error("unexpected result");
                errors++;
            end else begin
                e = expected_reads.pop_front();
                if (o_result.bin_count !== e.bin_count) begin
                    $error("bin_count exp %0d got %0d", e.bin_count, o_result.bin_count);
                    errors++;
                end
                if (o_result.peak_count !== e.peak_count) begin
                    $error("peak_count exp %0d got %0d", e.peak_count, o_result.peak_count);
                    errors++;
                end
                if (o_result.min_level !== e.min_level) begin
                    $error("min_level exp %0d got %0d", e.min_level, o_result.min_level);
                    errors++;
                end
                if (o_result.max_level !== e.max_level) begin
                    $error("max_level exp %0d got %0d", e.max_level, o_result.max_level);
                    errors++;
                end
                if (o_result.pixel_total !== e.pixel_total) begin
                    $error("pixel_total exp %0d got %0d", e.pixel_total,
                           o_result.pixel_total);
                    errors++;
                end
                if (o_result.channel_active !== e.channel_active) begin
                    $error("channel_active exp %0d got %0d", e.channel_active,
                           o_result.channel_active);
                    errors++;
                end
            end
        end
    end

    // Sends one command and waits until the block takes the transaction.
    task automatic send_cmd(t_in_item it);
        logic taken;
        i_item = it;
        start  = 1'b1;
        taken  = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        hist_apply(it);
        @(negedge i_clk);
        start = 1'b0;
    endtask

    // Gap-free burst variant: start stays high into the next transaction unless last.
    task automatic send_burst(t_in_item it, bit last);
        logic taken;
        i_item = it;
        start  = 1'b1;
        taken  = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            taken = !busy;
        end
        hist_apply(it);
        @(negedge i_clk);
        if (last) start = 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_reads.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_alpha_enable(logic v);
        i_cfg_data  = v;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        hist_alpha_enable = v;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    function automatic t_in_item mk(logic [1:0] op, logic [7:0] r, logic [7:0] g,
                                    logic [7:0] b, logic [7:0] a, logic [2:0] ch,
                                    logic [7:0] bn);
        t_in_item it;
        it.op = op; it.red = r; it.green = g; it.blue = b; it.alpha = a;
        it.channel = ch; it.bin = bn;
        return it;
    endfunction

    function automatic t_in_item rand_any(logic [1:0] op);
        return mk(op, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  3'($urandom), 8'($urandom));
    endfunction

    function automatic t_in_item rand_pixel();
        return rand_any(OP_PIXEL);
    endfunction

    // Reads cluster on a few levels so that nonzero bins are hit often.
    function automatic t_in_item rand_read();
        return mk(OP_READ, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom_range(0, 5) == 5 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4)),
                  $urandom_range(0, 1) ? 8'($urandom_range(0, 3) * 85) : 8'($urandom));
    endfunction

    // Directed table; rows with a typed result are checked against it as well.
    typedef struct {
        t_in_item  cmd;
        bit        has_typed;
        t_out_item typed;
    } t_dir_row;

    t_dir_row dir_rows [$];

    task automatic add_row(t_in_item it, bit has_typed = 0, t_out_item typed = '0);
        t_dir_row row;
        row.cmd = it; row.has_typed = has_typed; row.typed = typed;
        dir_rows.push_back(row);
    endtask

    initial begin
        t_out_item zero_res;
        t_out_item typed;
        int sent;
        int burst;
        hist_alpha_enable = 1'b0;
        hist_frame_open   = 1'b0;
        hist_frame_alpha  = 1'b0;
        hist_clear();
        zero_res = '0;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reads before any frame return all zeros.
        add_row(mk(OP_READ, 0, 0, 0, 0, CH_VALUE, 8'd0), 1, zero_res);
        add_row(mk(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0));
        add_row(mk(OP_READ, 0, 0, 0, 0, CH_RED, 8'd255), 1, zero_res);
        add_row(mk(OP_UNUSED, 8'hAA, 8'h55, 8'hAA, 8'h55, 3'd7, 8'hFF));
        add_row(mk(OP_START, 0, 0, 0, 0, 0, 0));
        // Empty frame: min 255, max 0, active.
        typed = '0; typed.min_level = 8'd255; typed.channel_active = 1'b1;
        add_row(mk(OP_READ, 0, 0, 0, 0, CH_BLUE, 8'd0), 1, typed);
        add_row(mk(OP_READ, 0, 0, 0, 0, CH_ALPHA, 8'd0), 1, zero_res);
        add_row(mk(OP_READ, 0, 0, 0, 0, 3'd7, 8'd0), 1, zero_res);
        add_row(mk(OP_PIXEL, 8'h00, 8'h00, 8'h00, 8'h00, 0, 0));
        add_row(mk(OP_PIXEL, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0, 0));
        add_row(mk(OP_PIXEL, 8'h12, 8'hC8, 8'h40, 8'h99, 0, 0));
        typed = '0; typed.bin_count = 32'd1; typed.peak_count = 32'd1;
        typed.min_level = 8'd0; typed.max_level = 8'd255; typed.pixel_total = 32'd3;
        typed.channel_active = 1'b1;
        add_row(mk(OP_READ, 0, 0, 0, 0, CH_VALUE, 8'd255), 1, typed);
        add_row(mk(OP_READ, 0, 0, 0, 0, CH_VALUE, 8'hC8));
        add_row(mk(OP_READ, 0, 0, 0, 0, CH_RED, 8'h12));
        add_row(mk(OP_READ, 0, 0, 0, 0, CH_GREEN, 8'h40));
        add_row(mk(OP_READ, 0, 0, 0, 0, 3'd5, 8'h00), 1, zero_res);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].has_typed && dir_rows[i].cmd.op == OP_READ) begin
                wait_idle();
                send_cmd(dir_rows[i].cmd);
                if (expected_reads[$] !== dir_rows[i].typed) begin
                    $error("typed row %0d disagrees with model", i);
                    errors++;
                end
            end else begin
                send_cmd(dir_rows[i].cmd);
            end
        end

        // Alpha frame with the register set.
        wait_idle();
        write_alpha_enable(1'b1);
        send_cmd(mk(OP_START, 0, 0, 0, 0, 0, 0));
        send_cmd(mk(OP_PIXEL, 8'h01, 8'h02, 8'h03, 8'hFE, 0, 0));
        send_cmd(mk(OP_READ, 0, 0, 0, 0, CH_ALPHA, 8'hFE));
        send_cmd(mk(OP_READ, 0, 0, 0, 0, CH_VALUE, 8'h03));

        // Random part: frames of pixels with reads mixed in; register varies.
        sent = 0;
        while (sent < 800) begin
            if ($urandom_range(0, 3) == 0) begin
                wait_idle();
                write_alpha_enable(1'($urandom_range(0, 1)));
            end
            send_cmd(rand_any(OP_START));
            sent++;
            for (int k = 0; k < $urandom_range(10, 60); k++) begin
                burst = $urandom_range(1, 8);
                for (int m = 0; m < burst; m++) begin
                    case ($urandom_range(0, 9))
                        0, 1, 2: send_burst(rand_read(), m == burst - 1);
                        3: send_burst(rand_any(OP_UNUSED), m == burst - 1);
                        default: send_burst(rand_pixel(), m == burst - 1);
                    endcase
                    sent++;
                end
                if ($urandom_range(0, 2) != 0)
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
            // Some frames drain all outstanding reads before the next frame start.
            if ($urandom_range(0, 4) == 0) wait_idle();
        end

        wait_idle();
        if (errors == 0 && expected_reads.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end
endmodule

>>> files.f
+incdir+rtl
rtl/rvh_pkg.sv
rtl/rvh_front.sv
rtl/rvh_back.sv
rtl/rgba_value_histogram_top.sv
tb/tb_top.sv
